// ===== sv/lob_pkg.sv =====
// lob_pkg: shared widths, record layouts, codes and priority search functions
// for the limit order book. No dependencies; used by every module but lob_ram.

package lob_pkg;

    localparam int ID_BITS    = 10;
    localparam int PRICE_BITS = 10;

    // an order count can reach the number of slots, so one bit more
    localparam int CNT_BITS = ID_BITS + 1;

    // occupancy map: price = {word index, bit index}
    localparam int LO_BITS  = (PRICE_BITS + 1) / 2;
    localparam int HI_BITS  = PRICE_BITS - LO_BITS;
    localparam int MAP_W    = 1 << LO_BITS;
    localparam int SUM_W    = 1 << HI_BITS;

    localparam int CLR_BITS = (ID_BITS > PRICE_BITS) ? ID_BITS : PRICE_BITS;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_CANCEL = 1'b1;
    localparam logic SIDE_BID    = 1'b0;
    localparam logic SIDE_ASK    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_DUP     = 2'd2
    } t_status;

    typedef struct packed {
        logic                  in_use;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
    } t_slot;

    typedef struct packed {
        logic [CNT_BITS-1:0] ask_cnt;
        logic [CNT_BITS-1:0] bid_cnt;
    } t_lvl;

    typedef struct packed {
        logic [MAP_W-1:0] ask_word;
        logic [MAP_W-1:0] bid_word;
    } t_map;

    // index of the highest set bit
    function automatic logic [LO_BITS-1:0] f_find_high(input logic [MAP_W-1:0] v);
        logic [LO_BITS-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (v[i]) idx = LO_BITS'(i);
        end
        return idx;
    endfunction

    // index of the lowest set bit
    function automatic logic [LO_BITS-1:0] f_find_low(input logic [MAP_W-1:0] v);
        logic [LO_BITS-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) idx = LO_BITS'(i);
        end
        return idx;
    endfunction

endpackage

// ===== sv/lob_ram.sv =====
// lob_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/limit_order_book_top.sv =====
// limit_order_book_top: order slots, level counts and occupancy map in RAM,
// driven by a read-modify-write sequencer. Depends on lob_pkg and lob_ram.

// After reset the block runs a clearing pass over its memories with o_ready low.
// It then handles one transaction at a time: o_ready is high only while the
// sequencer is idle. A request that changes nothing (market order, duplicate
// id, unknown id) goes from the slot step straight to the final step; any other
// add or cancel also updates the level counts and the occupancy map. A cancel
// that empties a price level then looks for the new best price of its side:
// the side is marked empty when its summary register is clear, and otherwise
// the new best price is found through the per-side summary register and one
// further read of the occupancy map RAM. The next request can be accepted at
// the edge where the result is first available. The result sits in an output
// register, so the next request is accepted while the previous result waits;
// a result that is not taken holds the following request in the final step.

module limit_order_book_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [lob_pkg::ID_BITS-1:0]   i_order_id,
    input  logic                          i_side,
    input  logic [lob_pkg::PRICE_BITS-1:0] i_price_ticks,
    input  logic                          i_is_market,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic                          o_bid_valid,
    output logic [lob_pkg::PRICE_BITS-1:0] o_bid_price,
    output logic                          o_ask_valid,
    output logic [lob_pkg::PRICE_BITS-1:0] o_ask_price
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SLOT  = 7'b0000100,
        S_LVL   = 7'b0001000,
        S_FIND  = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [lob_pkg::CLR_BITS-1:0]   r_clr_cnt, n_clr_cnt;
    logic                           r_mode, n_mode;
    logic [lob_pkg::ID_BITS-1:0]    r_id, n_id;
    logic                           r_side, n_side;
    logic [lob_pkg::PRICE_BITS-1:0] r_price, n_price;
    logic                           r_market, n_market;
    lob_pkg::t_status               r_status, n_status;
    logic [lob_pkg::HI_BITS-1:0]    r_hi, n_hi;
    logic                           r_bid_valid, n_bid_valid;
    logic [lob_pkg::PRICE_BITS-1:0] r_bid, n_bid;
    logic                           r_ask_valid, n_ask_valid;
    logic [lob_pkg::PRICE_BITS-1:0] r_ask, n_ask;
    logic [lob_pkg::SUM_W-1:0]      r_bid_sum, n_bid_sum;
    logic [lob_pkg::SUM_W-1:0]      r_ask_sum, n_ask_sum;
    logic                           r_out_valid, n_out_valid;
    lob_pkg::t_status               r_out_status, n_out_status;
    logic                           r_out_bid_valid, n_out_bid_valid;
    logic [lob_pkg::PRICE_BITS-1:0] r_out_bid, n_out_bid;
    logic                           r_out_ask_valid, n_out_ask_valid;
    logic [lob_pkg::PRICE_BITS-1:0] r_out_ask, n_out_ask;

    // memory ports
    logic                           slot_we;
    logic [lob_pkg::ID_BITS-1:0]    slot_waddr;
    lob_pkg::t_slot                 slot_wdata, slot_rdata;
    logic                           lvl_we;
    logic [lob_pkg::PRICE_BITS-1:0] lvl_waddr, lvl_raddr;
    lob_pkg::t_lvl                  lvl_wdata, lvl_rdata;
    logic                           map_we;
    logic [lob_pkg::HI_BITS-1:0]    map_waddr, map_raddr;
    lob_pkg::t_map                  map_wdata, map_rdata;

    // working values
    logic [lob_pkg::PRICE_BITS-1:0] w_lvl_price;
    logic [lob_pkg::CNT_BITS-1:0]   w_cnt_old, w_cnt_new;
    logic [lob_pkg::MAP_W-1:0]      w_word_old, w_word_new, w_bit;
    logic [lob_pkg::SUM_W-1:0]      w_sum;
    logic [lob_pkg::HI_BITS-1:0]    w_find_hi;
    logic [lob_pkg::LO_BITS-1:0]    w_find_lo;
    logic [lob_pkg::MAP_W-1:0]      w_scan_word;

    lob_ram #(.WIDTH($bits(lob_pkg::t_slot)), .DEPTH(1 << lob_pkg::ID_BITS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (i_order_id),
        .o_rdata (slot_rdata)
    );

    lob_ram #(.WIDTH($bits(lob_pkg::t_lvl)), .DEPTH(1 << lob_pkg::PRICE_BITS)) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    lob_ram #(.WIDTH($bits(lob_pkg::t_map)), .DEPTH(lob_pkg::SUM_W)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // level touched by this transaction: from the request on add, from the slot on cancel
    assign w_lvl_price = (r_mode == lob_pkg::MODE_CANCEL) ? slot_rdata.price : r_price;
    assign lvl_raddr   = w_lvl_price;

    assign w_sum = (r_side == lob_pkg::SIDE_ASK) ? r_ask_sum : r_bid_sum;
    assign w_find_hi = (r_side == lob_pkg::SIDE_ASK)
        ? lob_pkg::HI_BITS'(lob_pkg::f_find_low(lob_pkg::MAP_W'(w_sum)))
        : lob_pkg::HI_BITS'(lob_pkg::f_find_high(lob_pkg::MAP_W'(w_sum)));

    assign map_raddr = (r_state == S_FIND) ? w_find_hi
                                           : w_lvl_price[lob_pkg::PRICE_BITS-1:lob_pkg::LO_BITS];

    assign w_scan_word = (r_side == lob_pkg::SIDE_ASK) ? map_rdata.ask_word : map_rdata.bid_word;
    assign w_find_lo   = (r_side == lob_pkg::SIDE_ASK) ? lob_pkg::f_find_low(w_scan_word)
                                                       : lob_pkg::f_find_high(w_scan_word);

    assign w_cnt_old  = (r_side == lob_pkg::SIDE_ASK) ? lvl_rdata.ask_cnt : lvl_rdata.bid_cnt;
    assign w_word_old = (r_side == lob_pkg::SIDE_ASK) ? map_rdata.ask_word : map_rdata.bid_word;
    assign w_bit      = lob_pkg::MAP_W'(1) << r_price[lob_pkg::LO_BITS-1:0];

    always_comb begin
        if (r_mode == lob_pkg::MODE_ADD) begin
            w_cnt_new  = w_cnt_old + lob_pkg::CNT_BITS'(1);
            w_word_new = w_word_old | w_bit;
        end else begin
            w_cnt_new  = (w_cnt_old != '0) ? w_cnt_old - lob_pkg::CNT_BITS'(1) : '0;
            w_word_new = (w_cnt_new == '0) ? (w_word_old & ~w_bit) : w_word_old;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_clr_cnt       = r_clr_cnt;
        n_mode          = r_mode;
        n_id            = r_id;
        n_side          = r_side;
        n_price         = r_price;
        n_market        = r_market;
        n_status        = r_status;
        n_hi            = r_hi;
        n_bid_valid     = r_bid_valid;
        n_bid           = r_bid;
        n_ask_valid     = r_ask_valid;
        n_ask           = r_ask;
        n_bid_sum       = r_bid_sum;
        n_ask_sum       = r_ask_sum;
        n_out_valid     = r_out_valid;
        n_out_status    = r_out_status;
        n_out_bid_valid = r_out_bid_valid;
        n_out_bid       = r_out_bid;
        n_out_ask_valid = r_out_ask_valid;
        n_out_ask       = r_out_ask;

        slot_we    = 1'b0;
        slot_waddr = r_id;
        slot_wdata = '0;
        lvl_we     = 1'b0;
        lvl_waddr  = r_price;
        lvl_wdata  = lvl_rdata;
        map_we     = 1'b0;
        map_waddr  = r_price[lob_pkg::PRICE_BITS-1:lob_pkg::LO_BITS];
        map_wdata  = map_rdata;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr_cnt[lob_pkg::ID_BITS-1:0];
                slot_wdata = '0;
                lvl_we     = 1'b1;
                lvl_waddr  = r_clr_cnt[lob_pkg::PRICE_BITS-1:0];
                lvl_wdata  = '0;
                map_we     = 1'b1;
                map_waddr  = r_clr_cnt[lob_pkg::HI_BITS-1:0];
                map_wdata  = '0;
                n_clr_cnt  = r_clr_cnt + lob_pkg::CLR_BITS'(1);
                if (&r_clr_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_mode   = i_mode;
                    n_id     = i_order_id;
                    n_side   = i_side;
                    n_price  = i_price_ticks;
                    n_market = i_is_market;
                    n_state  = S_SLOT;
                end
            end
            S_SLOT: begin
                n_status = lob_pkg::ST_OK;
                n_state  = S_DONE;
                if (r_mode == lob_pkg::MODE_ADD) begin
                    if (!r_market) begin
                        if (slot_rdata.in_use) begin
                            n_status = lob_pkg::ST_DUP;
                        end else begin
                            slot_we    = 1'b1;
                            slot_wdata = '{in_use: 1'b1, side: r_side, price: r_price};
                            n_state    = S_LVL;
                            if (r_side == lob_pkg::SIDE_BID) begin
                                if (!r_bid_valid || r_price > r_bid) begin
                                    n_bid_valid = 1'b1;
                                    n_bid       = r_price;
                                end
                            end else begin
                                if (!r_ask_valid || r_price < r_ask) begin
                                    n_ask_valid = 1'b1;
                                    n_ask       = r_price;
                                end
                            end
                        end
                    end
                end else begin
                    if (!slot_rdata.in_use) begin
                        n_status = lob_pkg::ST_UNKNOWN;
                    end else begin
                        slot_we    = 1'b1;
                        slot_wdata = '{in_use: 1'b0, side: slot_rdata.side,
                                       price: slot_rdata.price};
                        n_side     = slot_rdata.side;
                        n_price    = slot_rdata.price;
                        n_state    = S_LVL;
                    end
                end
            end
            S_LVL: begin
                lvl_we = 1'b1;
                map_we = 1'b1;
                if (r_side == lob_pkg::SIDE_ASK) begin
                    lvl_wdata.ask_cnt  = w_cnt_new;
                    map_wdata.ask_word = w_word_new;
                    n_ask_sum[r_price[lob_pkg::PRICE_BITS-1:lob_pkg::LO_BITS]] = |w_word_new;
                end else begin
                    lvl_wdata.bid_cnt  = w_cnt_new;
                    map_wdata.bid_word = w_word_new;
                    n_bid_sum[r_price[lob_pkg::PRICE_BITS-1:lob_pkg::LO_BITS]] = |w_word_new;
                end
                // a level has just emptied: look for the new best
                if (r_mode == lob_pkg::MODE_CANCEL && w_cnt_new == '0) begin
                    n_state = S_FIND;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIND: begin
                if (w_sum == '0) begin
                    if (r_side == lob_pkg::SIDE_ASK) begin
                        n_ask_valid = 1'b0;
                        n_ask       = '0;
                    end else begin
                        n_bid_valid = 1'b0;
                        n_bid       = '0;
                    end
                    n_state = S_DONE;
                end else begin
                    n_hi    = w_find_hi;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_side == lob_pkg::SIDE_ASK) begin
                    n_ask_valid = 1'b1;
                    n_ask       = {r_hi, w_find_lo};
                end else begin
                    n_bid_valid = 1'b1;
                    n_bid       = {r_hi, w_find_lo};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid     = 1'b1;
                    n_out_status    = r_status;
                    n_out_bid_valid = r_bid_valid;
                    n_out_bid       = r_bid;
                    n_out_ask_valid = r_ask_valid;
                    n_out_ask       = r_ask;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_bid_valid <= 1'b0;
            r_bid       <= '0;
            r_ask_valid <= 1'b0;
            r_ask       <= '0;
            r_bid_sum   <= '0;
            r_ask_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_bid_valid <= n_bid_valid;
            r_bid       <= n_bid;
            r_ask_valid <= n_ask_valid;
            r_ask       <= n_ask;
            r_bid_sum   <= n_bid_sum;
            r_ask_sum   <= n_ask_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode          <= n_mode;
        r_id            <= n_id;
        r_side          <= n_side;
        r_price         <= n_price;
        r_market        <= n_market;
        r_status        <= n_status;
        r_hi            <= n_hi;
        r_out_status    <= n_out_status;
        r_out_bid_valid <= n_out_bid_valid;
        r_out_bid       <= n_out_bid;
        r_out_ask_valid <= n_out_ask_valid;
        r_out_ask       <= n_out_ask;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_bid_valid = r_out_bid_valid;
    assign o_bid_price = r_out_bid;
    assign o_ask_valid = r_out_ask_valid;
    assign o_ask_price = r_out_ask;

endmodule

// ===== sv/lob_checker.sv =====
// lob_checker: port-level checks on limit_order_book_top, bound to every instance.
// Depends on lob_pkg and limit_order_book_top.

module lob_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           i_mode,
    input logic [lob_pkg::ID_BITS-1:0]    i_order_id,
    input logic                           i_side,
    input logic [lob_pkg::PRICE_BITS-1:0] i_price_ticks,
    input logic                           i_is_market,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [1:0]                     o_status,
    input logic                           o_bid_valid,
    input logic [lob_pkg::PRICE_BITS-1:0] o_bid_price,
    input logic                           o_ask_valid,
    input logic [lob_pkg::PRICE_BITS-1:0] o_ask_price
);

    // one transaction in flight: no acceptance right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted on two consecutive cycles");

    // a result never appears in the cycle after its request was taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(i_valid && o_ready))
        else $error("result appeared too early");

    // empty side reports a zero price
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_bid_valid || o_bid_price == '0) && (o_ask_valid || o_ask_price == '0)))
        else $error("empty side with nonzero price");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_bid_price)
                                   && $stable(o_ask_price)))
        else $error("stalled result changed");

endmodule

bind limit_order_book_top lob_checker u_lob_checker (.*);

// ===== verif/limit_order_book_top_tb.sv =====
`timescale 1ns / 100ps
// limit_order_book_top_tb: self-checking bench for the limit order book top.
// Depends on lob_pkg and the limit_order_book_top RTL, which also needs lob_ram.

module limit_order_book_top_tb;
    import lob_pkg::*;

    localparam int SLOTS     = 1 << ID_BITS;
    localparam int LEVELS    = 1 << PRICE_BITS;
    localparam int MAX_ID    = SLOTS - 1;
    localparam int MAX_PRICE = LEVELS - 1;
    localparam int N_DIR     = 20;
    localparam int N_RAND    = 500;

    typedef struct packed {
        logic                  mode;
        logic [ID_BITS-1:0]    id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic                  market;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic                  bid_valid;
        logic [PRICE_BITS-1:0] bid_price;
        logic                  ask_valid;
        logic [PRICE_BITS-1:0] ask_price;
    } t_quote;

    typedef struct packed {
        t_req   req;
        logic   pinned;
        t_quote quote;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_mode;
    logic [ID_BITS-1:0]    i_order_id;
    logic                  i_side;
    logic [PRICE_BITS-1:0] i_price_ticks;
    logic                  i_is_market;
    logic                  o_valid;
    logic                  i_ready;
    logic [1:0]            o_status;
    logic                  o_bid_valid;
    logic [PRICE_BITS-1:0] o_bid_price;
    logic                  o_ask_valid;
    logic [PRICE_BITS-1:0] o_ask_price;

    // book shadow kept by the bench
    bit                  slot_in_use [SLOTS];
    bit                  slot_side   [SLOTS];
    bit [PRICE_BITS-1:0] slot_price  [SLOTS];
    bit [CNT_BITS-1:0]   bid_cnt     [LEVELS];
    bit [CNT_BITS-1:0]   ask_cnt     [LEVELS];
    bit                  bid_on;
    bit                  ask_on;
    bit [PRICE_BITS-1:0] top_bid;
    bit [PRICE_BITS-1:0] top_ask;
    int                  live_orders;

    t_quote pending_quotes [$];
    int     errors;
    int     quotes_seen;
    int     burst_left;
    int     price_centre;

    limit_order_book_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_order_id    (i_order_id),
        .i_side        (i_side),
        .i_price_ticks (i_price_ticks),
        .i_is_market   (i_is_market),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_bid_valid   (o_bid_valid),
        .o_bid_price   (o_bid_price),
        .o_ask_valid   (o_ask_valid),
        .o_ask_price   (o_ask_price)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH quote %0d: %s", quotes_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // applies one request to the shadow book and returns the quote it yields
    function automatic t_quote book_apply(input t_req r);
        t_quote q;
        bit [PRICE_BITS-1:0] p;
        q = '0;
        q.status = ST_OK;
        if (r.mode == MODE_ADD) begin
            if (!r.market) begin
                if (slot_in_use[r.id]) begin
                    q.status = ST_DUP;
                end else begin
                    slot_in_use[r.id] = 1'b1;
                    slot_side[r.id]   = r.side;
                    slot_price[r.id]  = r.price;
                    live_orders++;
                    if (r.side == SIDE_BID) begin
                        bid_cnt[r.price]++;
                        if (!bid_on || r.price > top_bid) begin
                            bid_on  = 1'b1;
                            top_bid = r.price;
                        end
                    end else begin
                        ask_cnt[r.price]++;
                        if (!ask_on || r.price < top_ask) begin
                            ask_on  = 1'b1;
                            top_ask = r.price;
                        end
                    end
                end
            end
        end else if (!slot_in_use[r.id]) begin
            q.status = ST_UNKNOWN;
        end else begin
            p = slot_price[r.id];
            slot_in_use[r.id] = 1'b0;
            live_orders--;
            if (slot_side[r.id] == SIDE_BID) begin
                if (bid_cnt[p] != 0) bid_cnt[p]--;
                // level emptied: look for the next highest occupied bid
                if (bid_cnt[p] == 0) begin
                    bid_on  = 1'b0;
                    top_bid = '0;
                    for (int k = MAX_PRICE; k >= 0; k--) begin
                        if (!bid_on && bid_cnt[k] != 0) begin
                            bid_on  = 1'b1;
                            top_bid = PRICE_BITS'(k);
                        end
                    end
                end
            end else begin
                if (ask_cnt[p] != 0) ask_cnt[p]--;
                if (ask_cnt[p] == 0) begin
                    ask_on  = 1'b0;
                    top_ask = '0;
                    for (int k = 0; k <= MAX_PRICE; k++) begin
                        if (!ask_on && ask_cnt[k] != 0) begin
                            ask_on  = 1'b1;
                            top_ask = PRICE_BITS'(k);
                        end
                    end
                end
            end
        end
        q.bid_valid = bid_on;
        q.bid_price = bid_on ? top_bid : '0;
        q.ask_valid = ask_on;
        q.ask_price = ask_on ? top_ask : '0;
        return q;
    endfunction

    function automatic t_row mk_row(input logic mode, input int id, input logic side,
                                    input int price, input int market,
                                    input int pinned, input t_status st,
                                    input int bv, input int bb,
                                    input int av, input int ba);
        t_row row;
        row.req    = '{mode, ID_BITS'(id), side, PRICE_BITS'(price), 1'(market)};
        row.pinned = 1'(pinned);
        row.quote  = '{st, 1'(bv), PRICE_BITS'(bb), 1'(av), PRICE_BITS'(ba)};
        return row;
    endfunction

    // scan from a random start for a slot that is (or is not) in use; -1 if none
    function automatic int find_slot(input bit want_used);
        int start;
        start = $urandom_range(0, MAX_ID);
        for (int k = 0; k < SLOTS; k++) begin
            if (slot_in_use[(start + k) % SLOTS] == want_used)
                return (start + k) % SLOTS;
        end
        return -1;
    endfunction

    function automatic logic [PRICE_BITS-1:0] pick_price();
        if ($urandom_range(0, 4) == 0)
            return PRICE_BITS'($urandom_range(0, MAX_PRICE));
        return PRICE_BITS'(price_centre + $urandom_range(0, 15) - 8);
    endfunction

    task automatic pick_request(output t_req r);
        int roll;
        int slot;
        int add_odds;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 32) == 0) price_centre = $urandom_range(0, MAX_PRICE);
        r = '{MODE_ADD, ID_BITS'($urandom), 1'($urandom), pick_price(), 1'b0};
        add_odds = (live_orders < 8) ? 80 : (live_orders > 40) ? 20 : 50;
        if (roll < 6) begin
            // noise: every field random
            r = '{1'($urandom), ID_BITS'($urandom), 1'($urandom),
                  PRICE_BITS'($urandom), 1'($urandom)};
        end else if (roll < 12) begin
            r.market = 1'b1;
        end else if (roll < 18 && live_orders > 0) begin
            // duplicate add on a live id
            r.id = ID_BITS'(find_slot(1'b1));
        end else if (roll < 24) begin
            // cancel of an arbitrary id, mostly unknown, ignored fields random
            r.mode   = MODE_CANCEL;
            r.market = 1'($urandom);
        end else if ($urandom_range(0, 99) < add_odds || live_orders == 0) begin
            slot = find_slot(1'b0);
            r.id = ID_BITS'(slot);
        end else begin
            r.mode   = MODE_CANCEL;
            r.id     = ID_BITS'(find_slot(1'b1));
            r.market = 1'($urandom);
        end
    endtask

    // one transaction on the request side, then maybe an idle gap
    task automatic send_request(input t_req r, input logic pinned, input t_quote pin_q);
        t_quote predicted;
        int gap;
        i_valid       <= 1'b1;
        i_mode        <= r.mode;
        i_order_id    <= r.id;
        i_side        <= r.side;
        i_price_ticks <= r.price;
        i_is_market   <= r.market;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        predicted = book_apply(r);
        pending_quotes.insert(pending_quotes.size(), pinned ? pin_q : predicted);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid       <= 1'b0;
                i_order_id    <= ID_BITS'($urandom);
                i_price_ticks <= PRICE_BITS'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver: stall style changes at each half turn of the phase counter
    bit [7:0] rdy_phase;
    int       rdy_style;
    always @(posedge i_clk) begin
        rdy_phase <= rdy_phase + 8'd1;
        if (rdy_phase == 8'd0 || rdy_phase == 8'd128) rdy_style <= $urandom_range(0, 3);
        case (rdy_style)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom);
            2: i_ready <= (rdy_phase[3:0] >= 4'd12);
            default: i_ready <= (rdy_phase[2:0] != 3'd0);
        endcase
    end

    always @(posedge i_clk) begin : quote_check
        t_quote want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_quotes.size() == 0) begin
                report_mismatch("quote with no request outstanding");
            end else begin
                want = pending_quotes.pop_front();
                check_field("status", o_status, want.status);
                check_field("bid_valid", o_bid_valid, want.bid_valid);
                check_field("bid_price", o_bid_price, want.bid_price);
                check_field("ask_valid", o_ask_valid, want.ask_valid);
                check_field("ask_price", o_ask_price, want.ask_price);
            end
            quotes_seen++;
        end
    end

    initial begin
        t_row dir_rows [N_DIR];
        t_req req;
        dir_rows = '{
            // empty book
            mk_row(MODE_CANCEL, 5, SIDE_BID, 0, 0, 1, ST_UNKNOWN, 0, 0, 0, 0),
            mk_row(MODE_ADD, 7, SIDE_BID, 500, 1, 1, ST_OK, 0, 0, 0, 0),
            // extremes of id and price
            mk_row(MODE_ADD, 0, SIDE_BID, 0, 0, 1, ST_OK, 1, 0, 0, 0),
            mk_row(MODE_ADD, MAX_ID, SIDE_ASK, MAX_PRICE, 0, 1, ST_OK, 1, 0, 1, MAX_PRICE),
            mk_row(MODE_ADD, 0, SIDE_BID, 300, 0, 1, ST_DUP, 1, 0, 1, MAX_PRICE),
            mk_row(MODE_ADD, 2, SIDE_BID, MAX_PRICE, 0, 1, ST_OK, 1, MAX_PRICE, 1, MAX_PRICE),
            mk_row(MODE_ADD, 3, SIDE_ASK, 0, 0, 1, ST_OK, 1, MAX_PRICE, 1, 0),
            // shared level, then emptied
            mk_row(MODE_ADD, 4, SIDE_ASK, 0, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_CANCEL, 3, SIDE_BID, 0, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_CANCEL, 4, SIDE_BID, 0, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_ADD, 10, SIDE_BID, 512, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_CANCEL, 2, SIDE_BID, 0, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_CANCEL, 2, SIDE_BID, 0, 0, 1, ST_UNKNOWN, 1, 512, 1, MAX_PRICE),
            // market order on an id in use is not checked
            mk_row(MODE_ADD, 10, SIDE_ASK, 1, 1, 0, ST_OK, 0, 0, 0, 0),
            // cancel with its unused fields all set
            mk_row(MODE_CANCEL, 10, SIDE_ASK, MAX_PRICE, 1, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_ADD, MAX_ID, SIDE_BID, 7, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_CANCEL, 0, SIDE_BID, 0, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_CANCEL, MAX_ID, SIDE_BID, 0, 0, 1, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_ADD, 512, SIDE_ASK, 1, 0, 0, ST_OK, 0, 0, 0, 0),
            mk_row(MODE_ADD, 513, SIDE_BID, 1, 0, 0, ST_OK, 0, 0, 0, 0)
        };
        errors        = 0;
        quotes_seen   = 0;
        live_orders   = 0;
        price_centre  = $urandom_range(0, MAX_PRICE);
        burst_left    = $urandom_range(1, 8);
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_mode        <= MODE_ADD;
        i_order_id    <= '0;
        i_side        <= SIDE_BID;
        i_price_ticks <= '0;
        i_is_market   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIR; n++)
            send_request(dir_rows[n].req, dir_rows[n].pinned, dir_rows[n].quote);
        for (int n = 0; n < N_RAND; n++) begin
            pick_request(req);
            send_request(req, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_quotes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // clearing pass plus ~520 transactions with worst gaps and stalls fits well inside
    initial begin
        #5_000_000;
        $display("TIMEOUT with %0d quotes outstanding", pending_quotes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
